// File: rtl/core/csvfs_pkg.sv
// Shared constants and helpers for the CSV field splitter.
package csvfs_pkg;

    // Field length counter width and size register width
    localparam int LENGTH_BITS_DEFAULT = 12;
    localparam int SIZE_W              = 13;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd256;

    // Byte codes of interest
    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] COMMA_CHAR = 8'h2C;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    // True for the whitespace class of separators
    function automatic logic is_space_sep(input logic [7:0] b);
        return (b == TAB_CHAR) || (b == SPACE_CHAR) || (b == CR_CHAR) ||
               (b == LF_CHAR) || (b == NUL_CHAR);
    endfunction

endpackage

// File: rtl/core/csv_field_splitter_top.sv
// CSV field splitter: byte stream in, field characters and field ends out.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one byte per request, or an
//   end_of_input marker that closes the open field. Output channel
//   (out_valid / out_stall) carries at most one result per input request:
//   a field character (char_valid), a field end (field_end) with the
//   running field length, or both when a field is cut at the size limit.
//   cfg_we / cfg_wdata write max_field_size; write it only while idle.
// Timing:
//   A request taken at a clock edge is decoded from the input register
//   stage and its result is written to the output register, or to the skid
//   register while a result waits. One request per cycle is sustained
//   while skid is empty; quote, whitespace and count flags update per request.
// Stall:
//   A two-entry output (result register plus skid register) keeps taking
//   requests while one result waits; in_stall rises only when the skid
//   register is full, and results are never dropped or repeated.
// Reset:
//   rst_n clears all flags, the field count and the channels, and loads
//   max_field_size with 256.
module csv_field_splitter_top
    import csvfs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [SIZE_W-1:0]      cfg_wdata,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_input,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   char_valid,
    output logic [7:0]             out_char,
    output logic                   field_end,
    output logic [LENGTH_BITS-1:0] field_length
);

    localparam int CMP_W = (LENGTH_BITS + 1 > SIZE_W) ? LENGTH_BITS + 1 : SIZE_W;
    localparam logic [CMP_W-1:0] LEN_CAP = CMP_W'(1) << LENGTH_BITS;

    // Configuration register
    logic [SIZE_W-1:0] max_size_reg;

    // Input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eoi_reg;

    // Parser state
    logic                   in_quotes_reg, in_quotes_next;
    logic                   quote_pend_reg, quote_pend_next;
    logic                   skip_space_reg, skip_space_next;
    logic [LENGTH_BITS-1:0] char_count_reg, char_count_next;

    // Result register and skid register
    logic                   out_valid_reg;
    logic                   out_cv_reg;
    logic [7:0]             out_char_reg;
    logic                   out_end_reg;
    logic [LENGTH_BITS-1:0] out_len_reg;
    logic                   skid_valid_reg;
    logic                   skid_cv_reg;
    logic [7:0]             skid_char_reg;
    logic                   skid_end_reg;
    logic [LENGTH_BITS-1:0] skid_len_reg;

    // Result of the current decode
    logic                   res_valid;
    logic                   res_cv;
    logic [7:0]             res_char;
    logic                   res_end;
    logic [LENGTH_BITS-1:0] res_len;

    logic                   in_take;
    logic                   s1_fire;
    logic                   out_take;
    logic                   is_space;
    logic                   is_quote;
    logic                   is_comma;
    logic                   literal_quote;
    logic                   quotes_after;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [CMP_W-1:0]       size_limit;
    logic                   len_cut;

    // Handshake
    assign in_stall = s1_valid_reg && skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // Hold the size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            max_size_reg <= cfg_wdata;
        end
    end

    // Load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_eoi_reg  <= end_of_input;
        end
    end

    // Classify the byte and build the length limit
    assign is_space      = is_space_sep(s1_byte_reg);
    assign is_quote      = (s1_byte_reg == QUOTE_CHAR);
    assign is_comma      = (s1_byte_reg == COMMA_CHAR);
    assign literal_quote = quote_pend_reg && is_quote;
    assign quotes_after  = (quote_pend_reg && !is_quote) ? 1'b0 : in_quotes_reg;
    assign count_inc     = char_count_reg + LENGTH_BITS'(1);
    assign size_limit    = (CMP_W'(max_size_reg) > LEN_CAP) ? LEN_CAP : CMP_W'(max_size_reg);
    assign len_cut       = (CMP_W'(count_inc) + CMP_W'(1)) >= size_limit;

    // Decode one byte against the quote and whitespace flags
    always_comb
    begin
        in_quotes_next  = in_quotes_reg;
        quote_pend_next = quote_pend_reg;
        skip_space_next = skip_space_reg;
        char_count_next = char_count_reg;
        res_valid       = 1'b0;
        res_cv          = 1'b0;
        res_char        = 8'h00;
        res_end         = 1'b0;
        res_len         = char_count_reg;
        if (s1_eoi_reg)
        begin
            // close the open field; nothing to report after whitespace
            res_valid       = !skip_space_reg;
            res_end         = 1'b1;
            in_quotes_next  = 1'b0;
            quote_pend_next = 1'b0;
            skip_space_next = 1'b0;
            char_count_next = '0;
        end
        else if (skip_space_reg && is_space)
        begin
            // drop further whitespace
        end
        else
        begin
            skip_space_next = 1'b0;
            quote_pend_next = 1'b0;
            in_quotes_next  = quotes_after;
            if (!literal_quote && is_quote)
            begin
                // open quotes, or wait for the byte after a closing quote
                in_quotes_next  = 1'b1;
                quote_pend_next = quotes_after;
            end
            else if (!literal_quote && !quotes_after && (is_comma || is_space))
            begin
                // separator ends the field
                skip_space_next = !is_comma;
                res_valid       = 1'b1;
                res_end         = 1'b1;
                in_quotes_next  = 1'b0;
                char_count_next = '0;
            end
            else
            begin
                // append a character, cut the field at the size limit
                res_valid = 1'b1;
                res_cv    = 1'b1;
                res_char  = s1_byte_reg;
                res_len   = count_inc;
                res_end   = len_cut;
                if (len_cut)
                begin
                    in_quotes_next  = 1'b0;
                    char_count_next = '0;
                end
                else
                begin
                    char_count_next = count_inc;
                end
            end
        end
    end

    // Advance the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            quote_pend_reg <= 1'b0;
            skip_space_reg <= 1'b0;
            char_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            in_quotes_reg  <= in_quotes_next;
            quote_pend_reg <= quote_pend_next;
            skip_space_reg <= skip_space_next;
            char_count_reg <= char_count_next;
        end
    end

    // Steer results into the result register or the skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (s1_fire && res_valid)
            begin
                if (out_valid_reg && out_stall)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_cv_reg   <= skid_cv_reg;
                out_char_reg <= skid_char_reg;
                out_end_reg  <= skid_end_reg;
                out_len_reg  <= skid_len_reg;
            end
        end
        else if (s1_fire && res_valid)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_cv_reg   <= res_cv;
                skid_char_reg <= res_char;
                skid_end_reg  <= res_end;
                skid_len_reg  <= res_len;
            end
            else
            begin
                out_cv_reg   <= res_cv;
                out_char_reg <= res_char;
                out_end_reg  <= res_end;
                out_len_reg  <= res_len;
            end
        end
    end

    // Drive the output channel
    assign out_valid    = out_valid_reg;
    assign char_valid   = out_cv_reg;
    assign out_char     = out_char_reg;
    assign field_end    = out_end_reg;
    assign field_length = out_len_reg;

    // A filled skid register always sits behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with no result in front");

    // A pending quote only exists inside quotes
    a_pend_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pend_reg |-> in_quotes_reg)
        else $error("quote pending outside quoted mode");

    // Whitespace skipping follows a closed, empty, unquoted field
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        skip_space_reg |-> (!in_quotes_reg && (char_count_reg == '0)))
        else $error("skipping whitespace with an open field");

    // A result without a character is always a field end
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_cv_reg) |-> out_end_reg)
        else $error("result carries neither a character nor a field end");

    // A stalled result holds while the skid register is full
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(skid_valid_reg) && $past(out_stall) && skid_valid_reg) |->
        $stable(out_char_reg))
        else $error("waiting result changed under stall");

endmodule
